FILE: hw/rtl/glyph_quad_text_layout_unit_assert.svh
// ----------------------------------------------------------------------------
// glyph quad text layout assertion macros
// concurrent checks clocked on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef GLYPH_QUAD_TEXT_LAYOUT_UNIT_ASSERT_SVH
`define GLYPH_QUAD_TEXT_LAYOUT_UNIT_ASSERT_SVH

// same-cycle implication
`define GQTL_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GQTL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/gqtl_pkg.sv
// ----------------------------------------------------------------------------
// gqtl_pkg
// types, codes and helpers shared by the glyph quad text layout unit
// ----------------------------------------------------------------------------
package gqtl_pkg;

  localparam int unsigned POS_W      = 24;
  localparam int unsigned BOX_W      = 16;
  localparam int unsigned TEX_W      = 16;
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned GAP_W      = 16;
  localparam int unsigned CORNER_W   = 3;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [BOX_W-1:0] box_t;
  typedef logic [TEX_W-1:0]        tex_t;
  typedef logic [CODE_W-1:0]       code_t;
  typedef logic [CORNER_W-1:0]     corner_t;

  typedef enum logic [1:0] {
    ACT_LAYOUT     = 2'd0,
    ACT_LOAD_GLYPH = 2'd1,
    ACT_LOAD_KERN  = 2'd2,
    ACT_START      = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_GLYPH   = 2'd1,
    OP_NEWLINE = 2'd2,
    OP_START   = 2'd3
  } op_e;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CODE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_GAP   = 4'd1;

  localparam code_t            NEWLINE_CODE   = 8'd10;
  localparam code_t            FIRST_CODE_RST = 8'd32;
  localparam logic [GAP_W-1:0] LINE_GAP_RST   = 16'd1024;
  localparam corner_t          LAST_CORNER    = 3'd5;

  typedef struct packed {
    box_t left;
    box_t bottom;
    box_t right;
    box_t top;
    tex_t u0;
    tex_t v0;
    tex_t u1;
    tex_t v1;
    box_t advance;
  } glyph_t;

  function automatic pos_t sat_add(pos_t a, logic signed [BOX_W:0] b);
    logic signed [POS_W:0] s;
    s = (POS_W+1)'(a) + (POS_W+1)'(b);
    if (s[POS_W] != s[POS_W-1]) begin
      return s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end
    return s[POS_W-1:0];
  endfunction

  // corners 2, 4, 5 take the right edge
  function automatic logic corner_right(corner_t c);
    case (c)
      3'd2, 3'd4, 3'd5: return 1'b1;
      default:          return 1'b0;
    endcase
  endfunction

  // corners 0, 3, 5 take the top edge
  function automatic logic corner_top(corner_t c);
    case (c)
      3'd0, 3'd3, 3'd5: return 1'b1;
      default:          return 1'b0;
    endcase
  endfunction

endpackage

FILE: hw/rtl/gqtl_in_if.sv
// ----------------------------------------------------------------------------
// gqtl_in_if
// input item channel: action, codes and glyph or kerning data
// ----------------------------------------------------------------------------
interface gqtl_in_if import gqtl_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  code_t       char_code;
  code_t       pair_code;
  box_t        box_left;
  box_t        box_bottom;
  box_t        box_right;
  box_t        box_top;
  tex_t        tex_left;
  tex_t        tex_bottom;
  tex_t        tex_right;
  tex_t        tex_top;
  box_t        spacing;

  modport source (
    output valid, action, char_code, pair_code, box_left, box_bottom, box_right,
           box_top, tex_left, tex_bottom, tex_right, tex_top, spacing,
    input  ready
  );

  modport sink (
    input  valid, action, char_code, pair_code, box_left, box_bottom, box_right,
           box_top, tex_left, tex_bottom, tex_right, tex_top, spacing,
    output ready
  );
endinterface

FILE: hw/rtl/gqtl_out_if.sv
// ----------------------------------------------------------------------------
// gqtl_out_if
// vertex channel: position, texture coordinate and corner number
// ----------------------------------------------------------------------------
interface gqtl_out_if import gqtl_pkg::*; ();
  logic    valid;
  logic    ready;
  pos_t    pos_x;
  pos_t    pos_y;
  tex_t    tex_u;
  tex_t    tex_v;
  corner_t corner;
  logic    last_vertex;

  modport source (
    output valid, pos_x, pos_y, tex_u, tex_v, corner, last_vertex,
    input  ready
  );

  modport sink (
    input  valid, pos_x, pos_y, tex_u, tex_v, corner, last_vertex,
    output ready
  );
endinterface

FILE: hw/rtl/gqtl_cfg_if.sv
// ----------------------------------------------------------------------------
// gqtl_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface gqtl_cfg_if import gqtl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

FILE: hw/rtl/glyph_quad_text_layout_unit.sv
// ----------------------------------------------------------------------------
// glyph_quad_text_layout_unit
// lays out a character stream as textured quads, six vertices per glyph
// ----------------------------------------------------------------------------
// Usage:
//   in_i takes one item per handshake: lay out a character, load a glyph,
//   load a kerning pair or start a new text. Loads, text starts, newlines
//   and codes outside the glyph table emit nothing.
//   A laid-out glyph gives six items on out_o, one per cycle while out_o is
//   ready, corners 0..5, last_vertex on corner 5; the vertex engine lets the
//   next glyph start right after corner 5. An accepted glyph passes through
//   the input stage and the engine register to the output register.
//   A newline or text start behind a glyph waits until that glyph's last
//   vertex has been loaded into the output register.
//   cfg_i writes first_code (index 0) and line_gap (index 1); it is always
//   ready and should only be used while the block is idle.
//   Reset zeroes the pen, clears the previous glyph and restores the
//   register defaults; glyph and kerning memories are not cleared.
//   When out_o stalls, the output register holds its vertex, the engine
//   pauses and in_i keeps accepting until the one-item input stage fills.
// ----------------------------------------------------------------------------
`include "glyph_quad_text_layout_unit_assert.svh"

module glyph_quad_text_layout_unit import gqtl_pkg::*; #(
  parameter int unsigned GLYPH_COUNT = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gqtl_in_if.sink    in_i,
  gqtl_out_if.source out_o,
  gqtl_cfg_if.sink   cfg_i
);

  localparam int unsigned IW = $clog2(GLYPH_COUNT);
  localparam int unsigned KD = GLYPH_COUNT * GLYPH_COUNT;
  localparam int unsigned KW = $clog2(KD);
  localparam logic [KW-1:0] GC_K = KW'(GLYPH_COUNT);
  localparam logic [CODE_W:0] GC_CMP = (CODE_W+1)'(GLYPH_COUNT);

  // configuration
  code_t            first_code_q;
  logic [GAP_W-1:0] line_gap_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_code_q <= FIRST_CODE_RST;
      line_gap_q   <= LINE_GAP_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_FIRST_CODE: first_code_q <= cfg_i.data[CODE_W-1:0];
        CFG_LINE_GAP:   line_gap_q   <= cfg_i.data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // front end: lookup, table writes, previous glyph tracking
  logic          in_fire;
  logic          s1_take;
  logic          s1_valid_q;
  op_e           s1_op_q;
  logic          s1_kern_en_q;
  logic [IW-1:0] prev_glyph_q;
  logic          prev_valid_q;

  logic [CODE_W:0] g_diff;
  logic [CODE_W:0] p_diff;
  logic            g_hit;
  logic            p_hit;
  logic [IW-1:0]   g_idx;
  logic [IW-1:0]   p_idx;
  action_e         act;
  logic            is_newline;

  op_e           op_d;
  logic          kern_en_d;
  logic [IW-1:0] prev_glyph_d;
  logic          prev_valid_d;
  logic          glyph_we;
  logic          kern_we;
  logic          rd_en;
  glyph_t        wr_glyph;
  logic [KW-1:0] kern_wr_addr;
  logic [KW-1:0] kern_rd_addr;

  assign in_i.ready = !s1_valid_q || s1_take;
  assign in_fire    = in_i.valid && in_i.ready;

  assign g_diff = {1'b0, in_i.char_code} - {1'b0, first_code_q};
  assign p_diff = {1'b0, in_i.pair_code} - {1'b0, first_code_q};
  assign g_hit  = !g_diff[CODE_W] && (g_diff < GC_CMP);
  assign p_hit  = !p_diff[CODE_W] && (p_diff < GC_CMP);
  assign g_idx  = g_diff[IW-1:0];
  assign p_idx  = p_diff[IW-1:0];
  assign act    = action_e'(in_i.action);
  assign is_newline = (in_i.char_code == NEWLINE_CODE);

  assign wr_glyph = '{
    left:    in_i.box_left,
    bottom:  in_i.box_bottom,
    right:   in_i.box_right,
    top:     in_i.box_top,
    u0:      in_i.tex_left,
    v0:      in_i.tex_bottom,
    u1:      in_i.tex_right,
    v1:      in_i.tex_top,
    advance: in_i.spacing
  };

  assign kern_wr_addr = KW'({{(KW-IW){1'b0}}, g_idx} * GC_K + {{(KW-IW){1'b0}}, p_idx});
  assign kern_rd_addr = KW'({{(KW-IW){1'b0}}, prev_glyph_q} * GC_K
                            + {{(KW-IW){1'b0}}, g_idx});

  always_comb begin
    op_d         = OP_NONE;
    kern_en_d    = 1'b0;
    prev_glyph_d = prev_glyph_q;
    prev_valid_d = prev_valid_q;
    glyph_we     = 1'b0;
    kern_we      = 1'b0;
    rd_en        = 1'b0;
    case (act)
      ACT_LAYOUT: begin
        if (is_newline) begin
          op_d         = OP_NEWLINE;
          prev_valid_d = 1'b0;
        end else if (g_hit) begin
          op_d         = OP_GLYPH;
          kern_en_d    = prev_valid_q;
          prev_glyph_d = g_idx;
          prev_valid_d = 1'b1;
          rd_en        = in_fire;
        end else begin
          prev_valid_d = 1'b0;
        end
      end
      ACT_LOAD_GLYPH: glyph_we = in_fire && g_hit;
      ACT_LOAD_KERN:  kern_we  = in_fire && g_hit && p_hit;
      ACT_START: begin
        op_d         = OP_START;
        prev_valid_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s1_op_q      <= OP_NONE;
      s1_kern_en_q <= 1'b0;
      prev_glyph_q <= '0;
      prev_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q   <= 1'b1;
        s1_op_q      <= op_d;
        s1_kern_en_q <= kern_en_d;
        prev_glyph_q <= prev_glyph_d;
        prev_valid_q <= prev_valid_d;
      end else if (s1_take) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // glyph and kerning memories
  glyph_t glyph_mem [GLYPH_COUNT];
  box_t   kern_mem  [KD];
  glyph_t rd_glyph_q;
  box_t   rd_kern_q;

  always_ff @(posedge clk_i) begin
    if (glyph_we) begin
      glyph_mem[g_idx] <= wr_glyph;
    end
    if (rd_en) begin
      rd_glyph_q <= glyph_mem[g_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (kern_we) begin
      kern_mem[kern_wr_addr] <= in_i.spacing;
    end
    if (rd_en) begin
      rd_kern_q <= kern_mem[kern_rd_addr];
    end
  end

  // vertex engine
  logic    busy_q;
  logic    busy_d;
  corner_t corner_q;
  corner_t corner_d;
  pos_t    pen_x_q;
  pos_t    pen_x_d;
  pos_t    pen_y_q;
  pos_t    pen_y_d;
  pos_t    pen_next_q;
  pos_t    pen_base;
  glyph_t  eng_q;
  logic    out_valid_q;
  logic    out_load;
  logic    emit;
  logic    last_emit;
  logic    glyph_start;
  logic signed [BOX_W:0] gap_neg;

  assign out_load    = !out_valid_q || out_o.ready;
  assign emit        = busy_q && out_load;
  assign last_emit   = emit && (corner_q == LAST_CORNER);
  assign s1_take     = s1_valid_q && ((s1_op_q == OP_NONE) || !busy_q || last_emit);
  assign glyph_start = s1_take && (s1_op_q == OP_GLYPH);
  assign pen_base    = last_emit ? pen_next_q : pen_x_q;
  assign gap_neg     = (BOX_W+1)'(0) - $signed({1'b0, line_gap_q});

  always_comb begin
    busy_d   = busy_q;
    corner_d = corner_q;
    pen_x_d  = pen_x_q;
    pen_y_d  = pen_y_q;
    if (emit) begin
      if (last_emit) begin
        busy_d   = 1'b0;
        corner_d = '0;
        pen_x_d  = pen_next_q;
      end else begin
        corner_d = corner_q + 3'd1;
      end
    end
    if (s1_take) begin
      case (s1_op_q)
        OP_GLYPH: begin
          busy_d   = 1'b1;
          corner_d = '0;
          pen_x_d  = s1_kern_en_q ? sat_add(pen_base, (BOX_W+1)'(rd_kern_q)) : pen_base;
        end
        OP_NEWLINE: begin
          pen_x_d = '0;
          pen_y_d = sat_add(pen_y_q, gap_neg);
        end
        OP_START: begin
          pen_x_d = '0;
          pen_y_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      corner_q    <= '0;
      pen_x_q     <= '0;
      pen_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      corner_q <= corner_d;
      pen_x_q  <= pen_x_d;
      pen_y_q  <= pen_y_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // pen after advance, ready well before the last corner
  always_ff @(posedge clk_i) begin
    pen_next_q <= sat_add(pen_x_q, (BOX_W+1)'(eng_q.advance));
    if (glyph_start) begin
      eng_q <= rd_glyph_q;
    end
  end

  // output register
  pos_t    out_pos_x_q;
  pos_t    out_pos_y_q;
  tex_t    out_tex_u_q;
  tex_t    out_tex_v_q;
  corner_t out_corner_q;
  logic    out_last_q;
  logic    sel_right;
  logic    sel_top;

  assign sel_right = corner_right(corner_q);
  assign sel_top   = corner_top(corner_q);

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_pos_x_q  <= sat_add(pen_x_q, (BOX_W+1)'(sel_right ? eng_q.right : eng_q.left));
      out_pos_y_q  <= sat_add(pen_y_q, (BOX_W+1)'(sel_top ? eng_q.top : eng_q.bottom));
      out_tex_u_q  <= sel_right ? eng_q.u1 : eng_q.u0;
      out_tex_v_q  <= sel_top ? eng_q.v1 : eng_q.v0;
      out_corner_q <= corner_q;
      out_last_q   <= (corner_q == LAST_CORNER);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pos_x       = out_pos_x_q;
  assign out_o.pos_y       = out_pos_y_q;
  assign out_o.tex_u       = out_tex_u_q;
  assign out_o.tex_v       = out_tex_v_q;
  assign out_o.corner      = out_corner_q;
  assign out_o.last_vertex = out_last_q;

  // checks
  `GQTL_ASSERT_NEXT(a_busy_holds, emit && !last_emit, busy_q, "engine dropped a glyph early")
  `GQTL_ASSERT_NEXT(a_corner_steps, emit && !last_emit,
                    corner_q == $past(corner_q) + 3'd1, "corner did not advance")
  `GQTL_ASSERT_NEXT(a_pen_stable, busy_q && !last_emit, $stable(pen_x_q),
                    "pen moved during a quad")
  `GQTL_ASSERT_NEXT(a_glyph_waits, s1_valid_q && (s1_op_q == OP_GLYPH) && busy_q && !last_emit,
                    s1_valid_q, "pending glyph lost while engine busy")

endmodule

FILE: tb/glyph_quad_text_layout_unit_tb.sv
// ----------------------------------------------------------------------------
// glyph_quad_text_layout_unit_tb
// drives glyph and kerning loads, text starts and characters into the layout
// unit, predicts every quad vertex from its own copy of the glyph tables and
// pen, and checks each vertex in order under random idling on both channels
// ----------------------------------------------------------------------------
module glyph_quad_text_layout_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gqtl_pkg::*;

  localparam int GLYPH_COUNT   = 128;
  localparam int POS_HI        = 8388607;
  localparam int POS_LO        = -8388608;
  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_ITEMS   = 5;
  localparam int SAT_RUN       = 130;
  // corners taking the right edge and the top edge
  localparam bit [5:0] RIGHT_CORNERS = 6'b110100;
  localparam bit [5:0] TOP_CORNERS   = 6'b101001;

  typedef struct packed {
    action_e action;
    code_t   char_code;
    code_t   pair_code;
    box_t    box_left, box_bottom, box_right, box_top;
    tex_t    tex_left, tex_bottom, tex_right, tex_top;
    box_t    spacing;
  } text_item_t;

  typedef struct packed {
    pos_t    pos_x;
    pos_t    pos_y;
    tex_t    tex_u;
    tex_t    tex_v;
    corner_t corner;
    logic    last_vertex;
  } vertex_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  gqtl_in_if  in_if();
  gqtl_out_if out_if();
  gqtl_cfg_if cfg_if();

  glyph_quad_text_layout_unit #(
    .GLYPH_COUNT(GLYPH_COUNT)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // layout state mirror
  int               glyph_box [GLYPH_COUNT][4];
  tex_t             glyph_tex [GLYPH_COUNT][4];
  int               glyph_adv [GLYPH_COUNT];
  bit               glyph_written [GLYPH_COUNT];
  int               kern_amt [GLYPH_COUNT*GLYPH_COUNT];
  bit               kern_written [GLYPH_COUNT*GLYPH_COUNT];
  int               pen_x;
  int               pen_y;
  int               prev_slot;
  bit               prev_live;
  code_t            first_code_q;
  logic [GAP_W-1:0] line_gap_q;

  vertex_t vertex_queue[$];
  int      errors;
  int      quiet_cycles;
  bit      steady_flow;

  function automatic int clamp24(int v);
    if (v > POS_HI) return POS_HI;
    if (v < POS_LO) return POS_LO;
    return v;
  endfunction

  function automatic int glyph_slot(code_t code);
    int d;
    d = int'(code) - int'(first_code_q);
    return (d >= 0 && d < GLYPH_COUNT) ? d : -1;
  endfunction

  function automatic void predict_layout(text_item_t it);
    int      g;
    int      h;
    int      xs;
    int      ys;
    vertex_t v;
    g = glyph_slot(it.char_code);
    case (it.action)
      ACT_LOAD_GLYPH: begin
        if (g >= 0) begin
          glyph_box[g][0] = int'($signed(it.box_left));
          glyph_box[g][1] = int'($signed(it.box_bottom));
          glyph_box[g][2] = int'($signed(it.box_right));
          glyph_box[g][3] = int'($signed(it.box_top));
          glyph_tex[g][0] = it.tex_left;
          glyph_tex[g][1] = it.tex_bottom;
          glyph_tex[g][2] = it.tex_right;
          glyph_tex[g][3] = it.tex_top;
          glyph_adv[g]    = int'($signed(it.spacing));
          glyph_written[g] = 1'b1;
        end
      end
      ACT_LOAD_KERN: begin
        h = glyph_slot(it.pair_code);
        if (g >= 0 && h >= 0) begin
          kern_amt[g*GLYPH_COUNT + h]     = int'($signed(it.spacing));
          kern_written[g*GLYPH_COUNT + h] = 1'b1;
        end
      end
      ACT_START: begin
        pen_x     = 0;
        pen_y     = 0;
        prev_live = 1'b0;
      end
      default: begin
        if (it.char_code == NEWLINE_CODE) begin
          pen_y     = clamp24(pen_y - int'(line_gap_q));
          pen_x     = 0;
          prev_live = 1'b0;
        end else if (g < 0) begin
          prev_live = 1'b0;
        end else begin
          if (prev_live) begin
            pen_x = clamp24(pen_x + kern_amt[prev_slot*GLYPH_COUNT + g]);
          end
          for (int k = 0; k < 6; k++) begin
            xs = RIGHT_CORNERS[k] ? 2 : 0;
            ys = TOP_CORNERS[k] ? 3 : 1;
            v.pos_x       = pos_t'(clamp24(pen_x + glyph_box[g][xs]));
            v.pos_y       = pos_t'(clamp24(pen_y + glyph_box[g][ys]));
            v.tex_u       = glyph_tex[g][xs];
            v.tex_v       = glyph_tex[g][ys];
            v.corner      = corner_t'(k);
            v.last_vertex = (corner_t'(k) == LAST_CORNER);
            vertex_queue = {vertex_queue, v};
          end
          pen_x     = clamp24(pen_x + glyph_adv[g]);
          prev_slot = g;
          prev_live = 1'b1;
        end
      end
    endcase
  endfunction

  function automatic box_t rand_offset();
    if ($urandom_range(0, 3) == 0) return box_t'($urandom);
    return box_t'($urandom_range(0, 4095)) - box_t'(2048);
  endfunction

  function automatic text_item_t random_item(action_e act, code_t code, code_t pair);
    text_item_t it;
    it.action     = act;
    it.char_code  = code;
    it.pair_code  = pair;
    it.box_left   = rand_offset();
    it.box_bottom = rand_offset();
    it.box_right  = rand_offset();
    it.box_top    = rand_offset();
    it.tex_left   = tex_t'($urandom);
    it.tex_bottom = tex_t'($urandom);
    it.tex_right  = tex_t'($urandom);
    it.tex_top    = tex_t'($urandom);
    it.spacing    = rand_offset();
    return it;
  endfunction

  function automatic void compare_field(string name, logic [23:0] want, logic [23:0] got);
    if (want !== got) begin
      $display("%0t ns: vertex %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin : check_vertices
    vertex_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (vertex_queue.size() == 0) begin
        $display("%0t ns: vertex with none expected, expected nothing actual corner %0d",
                 $time, out_if.corner);
        errors++;
      end else begin
        want = vertex_queue.pop_front();
        compare_field("pos_x", want.pos_x, out_if.pos_x);
        compare_field("pos_y", want.pos_y, out_if.pos_y);
        compare_field("tex_u", want.tex_u, out_if.tex_u);
        compare_field("tex_v", want.tex_v, out_if.tex_v);
        compare_field("corner", want.corner, out_if.corner);
        compare_field("last_vertex", want.last_vertex, out_if.last_vertex);
      end
    end
  end

  always @(negedge clk_i) begin
    out_if.ready <= steady_flow || ($urandom_range(0, 99) >= 13);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("glyph_quad_text_layout_unit verification failed");
      $finish;
    end
  end

  task automatic send_item(input text_item_t it);
    while (!steady_flow && $urandom_range(0, 99) < 13) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_if.valid      <= 1'b1;
    in_if.action     <= it.action;
    in_if.char_code  <= it.char_code;
    in_if.pair_code  <= it.pair_code;
    in_if.box_left   <= it.box_left;
    in_if.box_bottom <= it.box_bottom;
    in_if.box_right  <= it.box_right;
    in_if.box_top    <= it.box_top;
    in_if.tex_left   <= it.tex_left;
    in_if.tex_bottom <= it.tex_bottom;
    in_if.tex_right  <= it.tex_right;
    in_if.tex_top    <= it.tex_top;
    in_if.spacing    <= it.spacing;
    do @(posedge clk_i); while (!in_if.ready);
    predict_layout(it);
  endtask

  task automatic wait_drained(input bit settle);
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (vertex_queue.size() != 0) @(posedge clk_i);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == CFG_FIRST_CODE) begin
      first_code_q = value[CODE_W-1:0];
    end else if (idx == CFG_LINE_GAP) begin
      line_gap_q = value;
    end
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic start_text();
    send_item(random_item(ACT_START, code_t'($urandom), code_t'($urandom)));
  endtask

  // new text after every register change so no previous glyph crosses a remap
  task automatic set_registers(input code_t first, input logic [GAP_W-1:0] gap);
    wait_drained(1'b1);
    write_reg(CFG_FIRST_CODE, {8'($urandom), first});
    write_reg(CFG_LINE_GAP, gap);
    start_text();
  endtask

  task automatic load_glyph(input code_t code, input box_t l, input box_t b, input box_t r,
                            input box_t t, input tex_t u0, input tex_t v0, input tex_t u1,
                            input tex_t v1, input box_t adv);
    text_item_t it;
    it = random_item(ACT_LOAD_GLYPH, code, code_t'($urandom));
    it.box_left   = l;
    it.box_bottom = b;
    it.box_right  = r;
    it.box_top    = t;
    it.tex_left   = u0;
    it.tex_bottom = v0;
    it.tex_right  = u1;
    it.tex_top    = v1;
    it.spacing    = adv;
    send_item(it);
  endtask

  task automatic load_random_glyph(input code_t code);
    send_item(random_item(ACT_LOAD_GLYPH, code, code_t'($urandom)));
  endtask

  task automatic load_kern(input code_t first, input code_t second, input box_t amount);
    text_item_t it;
    it = random_item(ACT_LOAD_KERN, first, second);
    it.spacing = amount;
    send_item(it);
  endtask

  // loads whatever the character will read before laying it out
  task automatic lay_out(input code_t code);
    int slot;
    slot = glyph_slot(code);
    if (code != NEWLINE_CODE && slot >= 0) begin
      if (!glyph_written[slot]) load_random_glyph(code);
      if (prev_live && !kern_written[prev_slot*GLYPH_COUNT + slot]) begin
        load_kern(code_t'(prev_slot + int'(first_code_q)), code, rand_offset());
      end
    end
    send_item(random_item(ACT_LAYOUT, code, code_t'($urandom)));
  endtask

  task automatic test_basic_text();
    start_text();
    load_random_glyph(8'd65);
    load_random_glyph(8'd66);
    load_kern(8'd65, 8'd66, box_t'(300));
    lay_out(8'd65);
    lay_out(8'd66);
    lay_out(8'd5);
    lay_out(8'd66);
    lay_out(NEWLINE_CODE);
    lay_out(8'd65);
    lay_out(FIRST_CODE_RST);
    lay_out(FIRST_CODE_RST + 8'd127);
    lay_out(FIRST_CODE_RST + 8'd128);
    lay_out(FIRST_CODE_RST - 8'd1);
    start_text();
    lay_out(8'd66);
  endtask

  task automatic test_field_extremes();
    start_text();
    load_glyph(8'd67, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
               16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'sh7fff);
    load_glyph(8'd68, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
               16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'sh8000);
    load_glyph(8'd69, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
               16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'sh0000);
    load_kern(8'd67, 8'd68, 16'sh8000);
    load_kern(8'd68, 8'd67, 16'sh7fff);
    lay_out(8'd67);
    lay_out(8'd68);
    lay_out(8'd67);
    lay_out(8'd68);
    lay_out(8'd69);
  endtask

  task automatic test_register_extremes();
    set_registers(8'd0, 16'd0);
    load_random_glyph(NEWLINE_CODE);
    lay_out(8'd0);
    lay_out(NEWLINE_CODE);
    lay_out(8'd127);
    lay_out(8'd128);
    load_kern(NEWLINE_CODE, 8'd0, rand_offset());
    wait_drained(1'b1);
    write_reg(4'($urandom_range(2, 15)), 16'($urandom));
    set_registers(8'd255, 16'hffff);
    lay_out(8'd255);
    lay_out(8'd255);
    lay_out(NEWLINE_CODE);
    lay_out(8'd254);
    load_random_glyph(8'd254);
    load_kern(8'd255, 8'd3, rand_offset());
    lay_out(8'd255);
  endtask

  task automatic test_saturation();
    set_registers(FIRST_CODE_RST, 16'hffff);
    load_glyph(8'd83, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
               tex_t'($urandom), tex_t'($urandom), tex_t'($urandom), tex_t'($urandom),
               16'sh7fff);
    load_kern(8'd83, 8'd83, 16'sh7fff);
    repeat (SAT_RUN) lay_out(8'd83);
    lay_out(NEWLINE_CODE);
    repeat (2) lay_out(8'd83);
  endtask

  task automatic test_random_text();
    code_t   alphabet [6];
    code_t   first;
    int      span;
    int      pick;
    action_e act;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      first = (phase == 0) ? FIRST_CODE_RST : code_t'($urandom_range(0, 255));
      set_registers(first, 16'($urandom));
      steady_flow = (phase == 2);
      span = (256 - int'(first) < GLYPH_COUNT) ? 256 - int'(first) : GLYPH_COUNT;
      foreach (alphabet[i]) alphabet[i] = code_t'(int'(first) + $urandom_range(0, span - 1));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 1 && n == PHASE_ITEMS / 2) wait_drained(1'b0);
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          lay_out(alphabet[$urandom_range(0, 5)]);
        end else if (pick < 63) begin
          lay_out(NEWLINE_CODE);
        end else if (pick < 68) begin
          lay_out(code_t'($urandom));
        end else if (pick < 73) begin
          start_text();
        end else if (pick < 83) begin
          load_random_glyph(($urandom_range(0, 3) == 0) ? code_t'($urandom)
                                                         : alphabet[$urandom_range(0, 5)]);
        end else if (pick < 95) begin
          load_kern(alphabet[$urandom_range(0, 5)], alphabet[$urandom_range(0, 5)],
                    rand_offset());
        end else begin
          act = action_e'($urandom_range(0, 3));
          if (act == ACT_LAYOUT) begin
            lay_out(code_t'($urandom));
          end else begin
            send_item(random_item(act, code_t'($urandom), code_t'($urandom)));
          end
        end
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_ni           = 1'b0;
    errors           = 0;
    steady_flow      = 1'b0;
    pen_x            = 0;
    pen_y            = 0;
    prev_slot        = 0;
    prev_live        = 1'b0;
    first_code_q     = FIRST_CODE_RST;
    line_gap_q       = LINE_GAP_RST;
    in_if.valid      = 1'b0;
    in_if.action     = ACT_START;
    in_if.char_code  = '0;
    in_if.pair_code  = '0;
    in_if.box_left   = '0;
    in_if.box_bottom = '0;
    in_if.box_right  = '0;
    in_if.box_top    = '0;
    in_if.tex_left   = '0;
    in_if.tex_bottom = '0;
    in_if.tex_right  = '0;
    in_if.tex_top    = '0;
    in_if.spacing    = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CFG_FIRST_CODE;
    cfg_if.data      = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_basic_text();
    test_field_extremes();
    test_register_extremes();
    test_saturation();
    test_random_text();
    wait_drained(1'b1);

    if (errors == 0 && vertex_queue.size() == 0) begin
      $display("glyph_quad_text_layout_unit verification clean");
    end else begin
      $display("glyph_quad_text_layout_unit verification failed");
    end
    $finish;
  end

endmodule
